// File: rtl/core/aes_block_encrypt_decrypt_assert.svh
// Assertion macros used by the checker file aes_checker.sv.
`ifndef AES_BLOCK_ENCRYPT_DECRYPT_ASSERT_SVH
`define AES_BLOCK_ENCRYPT_DECRYPT_ASSERT_SVH

// Check a property on every rising edge of clock outside reset.
`define AES_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check that a condition in one cycle brings a consequence in the next.
`define AES_ASSERT_NEXT(label, cond, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/aes_pkg.sv
`default_nettype none
package aes_pkg;

   localparam logic [2:0] CSR_KEY_SIZE   = 3'd0;
   localparam logic [2:0] CSR_KEY_WORD_0 = 3'd1;
   localparam logic [2:0] CSR_KEY_WORD_1 = 3'd2;
   localparam logic [2:0] CSR_KEY_WORD_2 = 3'd3;
   localparam logic [2:0] CSR_KEY_WORD_3 = 3'd4;

   localparam int NUM_RK = 15;

   typedef struct packed {
      logic valid;
      logic mode;
   } ctrl_type;

   localparam logic [7:0] FWD_SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   localparam logic [7:0] INV_SBOX [256] = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
   };

   function automatic logic [7:0] xtime(input logic [7:0] x);
      return x[7] ? ({x[6:0], 1'b0} ^ 8'h1b) : {x[6:0], 1'b0};
   endfunction

   function automatic logic [31:0] sbox_word(input logic [31:0] w);
      return {FWD_SBOX[w[31:24]], FWD_SBOX[w[23:16]], FWD_SBOX[w[15:8]], FWD_SBOX[w[7:0]]};
   endfunction

   function automatic logic [127:0] sbox_state(input logic [127:0] s, input logic inv);
      logic [127:0] o;
      o = '0;
      for (int k = 0; k < 16; k++) begin
         o[8*k +: 8] = inv ? INV_SBOX[s[8*k +: 8]] : FWD_SBOX[s[8*k +: 8]];
      end
      return o;
   endfunction

   // byte k of the block sits at bits 127-8k; byte index is row + 4*column
   function automatic logic [127:0] row_rotate(input logic [127:0] s, input logic inv);
      logic [127:0] o;
      int src;
      o = '0;
      for (int k = 0; k < 16; k++) begin
         src = inv ? ((k % 4) + 4 * (((k / 4) + 4 - (k % 4)) % 4))
                   : ((k % 4) + 4 * (((k / 4) + (k % 4)) % 4));
         o[127 - 8*k -: 8] = s[127 - 8*src -: 8];
      end
      return o;
   endfunction

   function automatic logic [31:0] mix_col(input logic [31:0] c);
      logic [7:0] a0, a1, a2, a3;
      a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
      return {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
              a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
              a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
              xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
   endfunction

   function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
      logic [7:0] a [4];
      logic [7:0] m9 [4], mb [4], md [4], me [4];
      logic [7:0] x2, x4, x8;
      for (int k = 0; k < 4; k++) begin
         a[k]  = c[31 - 8*k -: 8];
         x2    = xtime(a[k]);
         x4    = xtime(x2);
         x8    = xtime(x4);
         m9[k] = x8 ^ a[k];
         mb[k] = x8 ^ x2 ^ a[k];
         md[k] = x8 ^ x4 ^ a[k];
         me[k] = x8 ^ x4 ^ x2;
      end
      return {me[0] ^ mb[1] ^ md[2] ^ m9[3],
              m9[0] ^ me[1] ^ mb[2] ^ md[3],
              md[0] ^ m9[1] ^ me[2] ^ mb[3],
              mb[0] ^ md[1] ^ m9[2] ^ me[3]};
   endfunction

   function automatic logic [127:0] column_mix(input logic [127:0] s, input logic inv);
      logic [127:0] o;
      o = '0;
      for (int c = 0; c < 4; c++) begin
         o[32*c +: 32] = inv ? inv_mix_col(s[32*c +: 32]) : mix_col(s[32*c +: 32]);
      end
      return o;
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/aes_round_cell.sv
`default_nettype none
module aes_round_cell (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              last_round,
   input  wire logic              bypass,
   input  wire logic [127:0]      key_enc,
   input  wire logic [127:0]      key_dec,
   input  wire aes_pkg::ctrl_type ctrl_in,
   input  wire logic [127:0]      data_in,
   output aes_pkg::ctrl_type      ctrl_out,
   output logic [127:0]           data_out
);

   aes_pkg::ctrl_type ctrl_ff;
   logic [127:0]      data_ff;
   logic [127:0]      enc_sr, enc_res, dec_add, dec_res, data_in_r;

   always_comb begin
      enc_sr  = aes_pkg::row_rotate(aes_pkg::sbox_state(data_in, 1'b0), 1'b0);
      enc_res = (last_round ? enc_sr : aes_pkg::column_mix(enc_sr, 1'b0)) ^ key_enc;
      dec_add = aes_pkg::sbox_state(aes_pkg::row_rotate(data_in, 1'b1), 1'b1) ^ key_dec;
      dec_res = last_round ? dec_add : aes_pkg::column_mix(dec_add, 1'b1);
      // rounds past the last one of the key size pass the block through
      if (bypass) begin
         data_in_r = data_in;
      end else begin
         data_in_r = ctrl_in.mode ? dec_res : enc_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (en) begin
         ctrl_ff <= ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in_r;
      end
   end

   assign ctrl_out = ctrl_ff;
   assign data_out = data_ff;

endmodule
`default_nettype wire

// File: rtl/core/aes_key_sched.sv
`default_nettype none
module aes_key_sched (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_wdata,
   output logic [3:0]       nr,
   output logic             busy,
   output logic [127:0]     rk_enc [aes_pkg::NUM_RK],
   output logic [127:0]     rk_dec [aes_pkg::NUM_RK]
);

   logic [1:0]  key_size_ff;
   logic [63:0] key_word_ff [4];
   logic        busy_ff;
   logic [5:0]  idx_ff;
   logic [2:0]  pos_ff;
   logic [7:0]  rc_ff;
   logic [31:0] win_ff [8];

   logic [3:0]  nk;
   logic [3:0]  nr_plus1;
   logic [5:0]  total;
   logic [63:0] kw;
   logic [31:0] cfg_word, temp, word_in;
   logic [3:0]  rnd, dec_slot;
   logic [1:0]  col;
   logic        restart;

   always_comb begin
      unique case (key_size_ff)
         2'd1:    nk = 4'd6;
         2'd2:    nk = 4'd8;
         default: nk = 4'd4;
      endcase
      nr       = nk + 4'd6;
      nr_plus1 = nr + 4'd1;
      total    = {nr_plus1, 2'b00};
      kw       = key_word_ff[idx_ff[2:1]];
      cfg_word = idx_ff[0] ? kw[31:0] : kw[63:32];
      temp     = win_ff[0];
      if (pos_ff == 3'd0) begin
         temp = aes_pkg::sbox_word({temp[23:0], temp[31:24]}) ^ {rc_ff, 24'd0};
      end else if (nk == 4'd8 && pos_ff == 3'd4) begin
         temp = aes_pkg::sbox_word(temp);
      end
      word_in  = (idx_ff < {2'b00, nk}) ? cfg_word : (win_ff[3'(nk - 4'd1)] ^ temp);
      rnd      = idx_ff[5:2];
      col      = idx_ff[1:0];
      dec_slot = nr - rnd;
      restart  = csr_we && (csr_index <= aes_pkg::CSR_KEY_WORD_3);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_size_ff <= '0;
         for (int k = 0; k < 4; k++) begin
            key_word_ff[k] <= '0;
         end
         busy_ff <= 1'b1;
         idx_ff  <= '0;
         pos_ff  <= '0;
         rc_ff   <= 8'h01;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               aes_pkg::CSR_KEY_SIZE:   key_size_ff    <= csr_wdata[1:0];
               aes_pkg::CSR_KEY_WORD_0: key_word_ff[0] <= csr_wdata;
               aes_pkg::CSR_KEY_WORD_1: key_word_ff[1] <= csr_wdata;
               aes_pkg::CSR_KEY_WORD_2: key_word_ff[2] <= csr_wdata;
               aes_pkg::CSR_KEY_WORD_3: key_word_ff[3] <= csr_wdata;
               default: ;
            endcase
         end
         // any key write starts the expansion over
         if (restart) begin
            busy_ff <= 1'b1;
            idx_ff  <= '0;
            pos_ff  <= '0;
            rc_ff   <= 8'h01;
         end else if (busy_ff) begin
            idx_ff  <= idx_ff + 6'd1;
            pos_ff  <= (pos_ff == 3'(nk - 4'd1)) ? 3'd0 : pos_ff + 3'd1;
            if (idx_ff >= {2'b00, nk} && pos_ff == 3'd0) begin
               rc_ff <= aes_pkg::xtime(rc_ff);
            end
            busy_ff <= (idx_ff != total - 6'd1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         rk_enc[rnd][{~col, 5'd0} +: 32]      <= word_in;
         rk_dec[dec_slot][{~col, 5'd0} +: 32] <= word_in;
         win_ff[0] <= word_in;
         for (int k = 1; k < 8; k++) begin
            win_ff[k] <= win_ff[k-1];
         end
      end
   end

   assign busy = busy_ff;

endmodule
`default_nettype wire

// File: rtl/core/aes_block_encrypt_decrypt.sv
// AES-128/192/256 encrypt and decrypt, one round per cell in a row of 14 cells.
// A request goes through one add-key stage and then the 14 cells before rsp_tvalid.
// Throughput: one block per cycle; the whole row holds while rsp_tvalid waits.
// Reset (synchronous) and every key register write rerun the key expansion,
// one schedule word per cycle, with req_tready low while it runs.
`default_nettype none
module aes_block_encrypt_decrypt (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [127:0] req_tdata,   // data_high [63:0], data_low [127:64]
   input  wire logic [0:0]   req_tuser,   // mode [0]
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [127:0]      rsp_tdata,   // result_high [63:0], result_low [127:64]
   input  wire logic         csr_we,
   input  wire logic [2:0]   csr_index,
   input  wire logic [63:0]  csr_wdata
);

   logic [3:0]        nr;
   logic              busy;
   logic [127:0]      rk_enc [aes_pkg::NUM_RK];
   logic [127:0]      rk_dec [aes_pkg::NUM_RK];
   logic              en;
   aes_pkg::ctrl_type ctrl0_in, ctrl0_ff;
   logic [127:0]      data0_in, data0_ff;
   aes_pkg::ctrl_type ctrl_s [aes_pkg::NUM_RK];
   logic [127:0]      data_s [aes_pkg::NUM_RK];

   aes_key_sched u_key_sched (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .nr        (nr),
      .busy      (busy),
      .rk_enc    (rk_enc),
      .rk_dec    (rk_dec)
   );

   always_comb begin
      en             = !rsp_tvalid || rsp_tready;
      req_tready     = en && !busy;
      ctrl0_in.valid = req_tvalid && req_tready;
      ctrl0_in.mode  = req_tuser[0];
      data0_in       = {req_tdata[63:0], req_tdata[127:64]}
                       ^ (req_tuser[0] ? rk_dec[0] : rk_enc[0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl0_ff <= '0;
      end else if (en) begin
         ctrl0_ff <= ctrl0_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data0_ff <= data0_in;
      end
   end

   assign ctrl_s[0] = ctrl0_ff;
   assign data_s[0] = data0_ff;

   for (genvar r = 1; r < aes_pkg::NUM_RK; r++) begin : g_cell
      aes_round_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .en         (en),
         .last_round (nr == 4'(r)),
         .bypass     (4'(r) > nr),
         .key_enc    (rk_enc[r]),
         .key_dec    (rk_dec[r]),
         .ctrl_in    (ctrl_s[r-1]),
         .data_in    (data_s[r-1]),
         .ctrl_out   (ctrl_s[r]),
         .data_out   (data_s[r])
      );
   end

   assign rsp_tvalid = ctrl_s[aes_pkg::NUM_RK-1].valid;
   assign rsp_tdata  = {data_s[aes_pkg::NUM_RK-1][63:0], data_s[aes_pkg::NUM_RK-1][127:64]};

endmodule
`default_nettype wire

// File: rtl/core/aes_checker.sv
`default_nettype none
`include "aes_block_encrypt_decrypt_assert.svh"
module aes_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tready,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [127:0] rsp_tdata,
   input wire logic         csr_we,
   input wire logic [2:0]   csr_index
);

   `AES_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled response changed")
   `AES_ASSERT_NEXT(a_key_write_blocks, csr_we && csr_index <= aes_pkg::CSR_KEY_WORD_3, !req_tready, "request taken during key expansion")
   `AES_ASSERT(a_stall_blocks, (rsp_tvalid && !rsp_tready) |-> !req_tready, "request taken while output stalled")

endmodule

bind aes_block_encrypt_decrypt aes_checker u_checker (.*);
`default_nettype wire

// File: test/aes_block_encrypt_decrypt_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module aes_block_encrypt_decrypt_tb;

   localparam int STALL_LIMIT = 4000;

   typedef logic [15:0][7:0] aes_state_type;

   typedef struct packed {
      logic [63:0] result_high;
      logic [63:0] result_low;
   } aes_result_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [127:0] req_tdata;
   logic [0:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [127:0] rsp_tdata;
   logic         csr_we;
   logic [2:0]   csr_index;
   logic [63:0]  csr_wdata;

   aes_block_encrypt_decrypt u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // predictor state
   logic [7:0]  sbox_fwd [256];
   logic [7:0]  sbox_inv [256];
   logic [1:0]  key_size_q;
   logic [63:0] key_word_q [4];
   logic [31:0] sched_q [15][4];

   aes_result_type cipher_q [$];
   int          error_count = 0;
   int          idle_cycles = 0;
   bit          no_stall = 0;
   int          sink_hold = 0;

   initial clock = 1'b0;
   always #1 clock = ~clock;

   function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] acc;
      acc = 8'h00;
      for (int k = 0; k < 8; k++) begin
         if (b[0]) acc = acc ^ a;
         a = a[7] ? ({a[6:0], 1'b0} ^ 8'h1b) : {a[6:0], 1'b0};
         b = b >> 1;
      end
      return acc;
   endfunction

   // build the forward and inverse S-boxes from the field inverse and the affine map
   task automatic build_sboxes();
      logic [7:0] b, s;
      for (int x = 0; x < 256; x++) begin
         b = 8'h00;
         for (int y = 1; y < 256; y++)
            if (x != 0 && gmul(x[7:0], y[7:0]) == 8'h01) b = y[7:0];
         s = b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]} ^ {b[3:0], b[7:4]}
             ^ 8'h63;
         sbox_fwd[x] = s;
         sbox_inv[s] = x[7:0];
      end
   endtask

   function automatic int key_words();
      return key_size_q == 2'd1 ? 6 : (key_size_q == 2'd2 ? 8 : 4);
   endfunction

   function automatic logic [31:0] sub_w(input logic [31:0] w);
      return {sbox_fwd[w[31:24]], sbox_fwd[w[23:16]], sbox_fwd[w[15:8]], sbox_fwd[w[7:0]]};
   endfunction

   task automatic expand_schedule();
      logic [31:0] w [60];
      logic [31:0] t;
      logic [7:0]  rc;
      int nk, total;
      nk = key_words();
      total = 4 * (nk + 7);
      rc = 8'h01;
      for (int i = 0; i < 60; i++) w[i] = '0;
      for (int i = 0; i < nk; i++)
         w[i] = (i % 2) ? key_word_q[i / 2][31:0] : key_word_q[i / 2][63:32];
      for (int i = nk; i < total; i++) begin
         t = w[i - 1];
         if (i % nk == 0) begin
            t = sub_w({t[23:0], t[31:24]}) ^ {rc, 24'h0};
            rc = gmul(rc, 8'h02);
         end else if (nk > 6 && i % nk == 4) begin
            t = sub_w(t);
         end
         w[i] = w[i - nk] ^ t;
      end
      for (int i = 0; i < 60; i++) sched_q[i / 4][i % 4] = (i < total) ? w[i] : '0;
   endtask

   function automatic aes_state_type add_rk(input aes_state_type s, input int r);
      for (int c = 0; c < 4; c++)
         for (int k = 0; k < 4; k++)
            s[4*c + k] = s[4*c + k] ^ sched_q[r][c][31 - 8*k -: 8];
      return s;
   endfunction

   function automatic aes_state_type sub_st(input aes_state_type s, input bit inv);
      for (int i = 0; i < 16; i++) s[i] = inv ? sbox_inv[s[i]] : sbox_fwd[s[i]];
      return s;
   endfunction

   function automatic aes_state_type rot_st(input aes_state_type s, input bit inv);
      aes_state_type t;
      t = s;
      for (int r = 1; r < 4; r++)
         for (int c = 0; c < 4; c++)
            s[r + 4*c] = t[r + 4*(inv ? ((c + 4 - r) % 4) : ((c + r) % 4))];
      return s;
   endfunction

   function automatic aes_state_type mix_st(input aes_state_type s, input bit inv);
      logic [7:0] m [4];
      logic [7:0] col [4];
      logic [7:0] acc;
      if (inv) m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
      else m = '{8'h02, 8'h03, 8'h01, 8'h01};
      for (int c = 0; c < 4; c++) begin
         for (int k = 0; k < 4; k++) col[k] = s[4*c + k];
         for (int r = 0; r < 4; r++) begin
            acc = 8'h00;
            for (int k = 0; k < 4; k++) acc = acc ^ gmul(m[(k + 4 - r) % 4], col[k]);
            s[4*c + r] = acc;
         end
      end
      return s;
   endfunction

   function automatic aes_result_type predict_block(input bit decrypt, input logic [63:0] hi,
                                                    input logic [63:0] lo);
      aes_state_type  s;
      aes_result_type res;
      int nr;
      nr = key_words() + 6;
      for (int i = 0; i < 8; i++) begin
         s[i]     = hi[63 - 8*i -: 8];
         s[i + 8] = lo[63 - 8*i -: 8];
      end
      if (!decrypt) begin
         s = add_rk(s, 0);
         for (int r = 1; r < nr; r++) s = add_rk(mix_st(rot_st(sub_st(s, 0), 0), 0), r);
         s = add_rk(rot_st(sub_st(s, 0), 0), nr);
      end else begin
         s = add_rk(s, nr);
         for (int r = nr - 1; r >= 1; r--) s = mix_st(add_rk(sub_st(rot_st(s, 1), 1), r), 1);
         s = add_rk(sub_st(rot_st(s, 1), 1), 0);
      end
      for (int i = 0; i < 8; i++) begin
         res.result_high[63 - 8*i -: 8] = s[i];
         res.result_low[63 - 8*i -: 8]  = s[i + 8];
      end
      return res;
   endfunction

   function automatic int pick_gap();
      int p;
      p = $urandom_range(99);
      if (no_stall || p < 60) return 0;
      if (p < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   // result sink: random backpressure, always ready while no_stall is set
   always @(posedge clock) begin
      if (no_stall) begin
         rsp_tready <= 1'b1;
      end else if (sink_hold > 0) begin
         sink_hold <= sink_hold - 1;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(99) < 25) begin
         sink_hold <= pick_gap();
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // result checker
   always @(posedge clock) begin
      aes_result_type exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (cipher_q.size() == 0) begin
            $display("%0t: unexpected result %h", $time, rsp_tdata);
            error_count++;
         end else begin
            exp_r = cipher_q.pop_front();
            if (rsp_tdata[63:0] !== exp_r.result_high) begin
               $display("%0t: result_high expected %h actual %h", $time,
                        exp_r.result_high, rsp_tdata[63:0]);
               error_count++;
            end
            if (rsp_tdata[127:64] !== exp_r.result_low) begin
               $display("%0t: result_low expected %h actual %h", $time,
                        exp_r.result_low, rsp_tdata[127:64]);
               error_count++;
            end
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || cipher_q.size() == 0 && !req_tvalid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("aes_block_encrypt_decrypt_tb NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_block(input bit decrypt, input logic [63:0] hi, input logic [63:0] lo);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {lo, hi};
      req_tuser  <= decrypt;
      do @(posedge clock); while (!req_tready);
      cipher_q.push_back(predict_block(decrypt, hi, lo));
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (cipher_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
      drain();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         aes_pkg::CSR_KEY_SIZE:   key_size_q = value[1:0];
         aes_pkg::CSR_KEY_WORD_0: key_word_q[0] = value;
         aes_pkg::CSR_KEY_WORD_1: key_word_q[1] = value;
         aes_pkg::CSR_KEY_WORD_2: key_word_q[2] = value;
         aes_pkg::CSR_KEY_WORD_3: key_word_q[3] = value;
         default: ;
      endcase
      expand_schedule();
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] pick_data();
      int p;
      p = $urandom_range(19);
      if (p == 0) return '0;
      if (p == 1) return '1;
      return rand64();
   endfunction

   task automatic load_key(input logic [1:0] size, input logic [63:0] k0, input logic [63:0] k1,
                           input logic [63:0] k2, input logic [63:0] k3);
      write_reg(aes_pkg::CSR_KEY_SIZE, {62'h0, size});
      write_reg(aes_pkg::CSR_KEY_WORD_0, k0);
      write_reg(aes_pkg::CSR_KEY_WORD_1, k1);
      write_reg(aes_pkg::CSR_KEY_WORD_2, k2);
      write_reg(aes_pkg::CSR_KEY_WORD_3, k3);
   endtask

   task automatic test_before_key();
      send_block(0, '0, '0);
      send_block(1, '0, '0);
      send_block(0, '1, '1);
      send_block(1, 64'h0011223344556677, 64'h8899aabbccddeeff);
   endtask

   task automatic test_key_sizes();
      aes_result_type ct;
      load_key(2'd0, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, '1, '1);
      send_block(0, 64'h0011223344556677, 64'h8899aabbccddeeff);
      load_key(2'd1, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h1011121314151617, '1);
      send_block(0, 64'h0011223344556677, 64'h8899aabbccddeeff);
      load_key(2'd2, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h1011121314151617,
               64'h18191a1b1c1d1e1f);
      send_block(0, 64'h0011223344556677, 64'h8899aabbccddeeff);
      ct = predict_block(0, 64'h0011223344556677, 64'h8899aabbccddeeff);
      send_block(1, ct.result_high, ct.result_low);
      load_key(2'd2, '1, '1, '1, '1);
      send_block(0, '1, '1);
      send_block(1, '0, '0);
      // size 3 acts as 128-bit key
      load_key(2'd3, '1, '0, '1, '0);
      send_block(0, '1, '0);
      send_block(1, '0, '1);
   endtask

   task automatic test_bad_index();
      write_reg(3'd5, rand64());
      write_reg(3'd6, rand64());
      write_reg(3'd7, '1);
      send_block(0, 64'h8000000000000001, 64'h0123456789abcdef);
      send_block(1, 64'h8000000000000001, 64'h0123456789abcdef);
   endtask

   task automatic test_random_traffic();
      logic [1:0] size;
      for (int ph = 0; ph < 8; ph++) begin
         size = (ph < 3) ? ph[1:0] : 2'($urandom_range(3));
         if (ph == 7) size = 2'd2;
         if (ph == 3) load_key(size, '0, '0, '0, '0);
         else if (ph == 4) load_key(size, '1, '1, '1, '1);
         else load_key(size, rand64(), rand64(), rand64(), rand64());
         no_stall = (ph == 5);
         for (int n = 0; n < 235; n++) begin
            send_block(1'($urandom_range(1)), pick_data(), pick_data());
            if (n == 117 && ph == 2) drain();
         end
      end
      no_stall = 0;
   endtask

   initial begin
      build_sboxes();
      key_size_q = 2'd0;
      for (int i = 0; i < 4; i++) key_word_q[i] = '0;
      expand_schedule();
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      rsp_tready <= 1'b0;
      csr_we     <= 1'b0;
      csr_index  <= '0;
      csr_wdata  <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_before_key();
      test_key_sizes();
      test_bad_index();
      test_random_traffic();
      drain();
      if (error_count == 0) $display("aes_block_encrypt_decrypt_tb OK");
      else $display("aes_block_encrypt_decrypt_tb NOT OK");
      $finish;
   end

endmodule
`default_nettype wire
